[design/adh_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package adh_pkg;

  // one analysis frame
  typedef struct packed {
    logic        [15:0] tempo;
    logic signed [15:0] surround_level;
    logic signed [15:0] band_hi;
    logic signed [15:0] band_mid;
    logic signed [15:0] band_lo;
  } frame_t;

  // one detection result
  typedef struct packed {
    logic       excitement_rise;
    logic       volume_rise;
    logic       tempo_stable;
    logic [1:0] flag_total;
    logic       hook_detected;
  } result_t;

  // entry of the level delay line: surround and the three-band sum
  typedef struct packed {
    logic signed [15:0] surround;
    logic signed [17:0] band_sum;
  } level_t;

  // register indexes
  localparam logic [2:0] REG_COOLDOWN  = 3'd0;
  localparam logic [2:0] REG_RISE_THR  = 3'd1;
  localparam logic [2:0] REG_TEMPO_TOL = 3'd2;
  localparam logic [2:0] REG_VOL_GAIN  = 3'd3;
  localparam logic [2:0] REG_MIN_SCORE = 3'd4;

  // register reset values
  localparam logic [15:0] COOLDOWN_RST  = 16'd100;
  localparam logic [15:0] RISE_THR_RST  = 16'd256;
  localparam logic [15:0] TEMPO_TOL_RST = 16'd640;
  localparam logic [15:0] VOL_GAIN_RST  = 16'd18022;
  localparam logic [1:0]  MIN_SCORE_RST = 2'd2;

  // gap counter
  localparam logic [15:0] GAP_RST = 16'd1000;
  localparam logic [15:0] GAP_MAX = 16'hffff;

  // volume comparison scale, Q2.14 unity
  localparam int VOL_UNITY_SHIFT = 14;

  // default sizes
  localparam int HISTORY_LEN_DEF  = 20;
  localparam int LAG_DEF          = 10;
  localparam int TEMPO_WINDOW_DEF = 10;

endpackage

`default_nettype wire

[design/audio_hook_detector.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel | direction | handshake          | word
// --------+-----------+--------------------+-------------------------------
// in      | input     | in_valid/in_stall  | frame_t: tempo and four levels
// out     | output    | out_valid/out_stall| result_t: three flags, score, hook
// cfg     | input     | cfg_valid/cfg_ready| register index and write data
//
// one word per cycle sustained while out_stall stays low; the accepting edge shifts a frame into the
// history, and its result word, formed by the flag logic (volume multiplier, tempo deviation
// compares), is taken into the output register once that register is empty or being drained
// sync reset empties the history, gap counter to 1000, registers to defaults
// in_stall rises only while a shifted frame waits behind a stalled output
// cfg_ready is always high
module audio_hook_detector
  import adh_pkg::*;
#(
  parameter int HISTORY_LEN  = HISTORY_LEN_DEF,
  parameter int LAG          = LAG_DEF,
  parameter int TEMPO_WINDOW = TEMPO_WINDOW_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire frame_t      in_data,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      result_t     out_data,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  // widths; FILL_W and SUM_W derived from the sizes
  localparam int FILL_W = $clog2(HISTORY_LEN + 1);
  localparam int SUM_W  = 16 + $clog2(TEMPO_WINDOW);
  localparam int PROD_W = 35;

  // configuration registers
  logic [15:0] hold_off;
  logic [15:0] rise_threshold;
  logic [15:0] tempo_tolerance;
  logic [15:0] volume_gain;
  logic [1:0]  min_score;

  // history
  logic [15:0]      tempo_window [TEMPO_WINDOW];
  logic [SUM_W-1:0] tempo_sum;
  logic [SUM_W-1:0] tempo_sum_next;
  level_t           level_delay  [LAG+1];
  level_t           level_in;
  logic [FILL_W-1:0] fill_count;
  logic             pending;   // history holds a frame not yet scored

  // gap since the last hook
  logic [15:0] gap;

  // handshakes
  logic accept;
  logic advance;

  // flag logic
  logic                     full;
  logic signed [17:0]       surround_diff;
  logic                     exc;
  logic signed [PROD_W-1:0] now_prod;
  logic signed [PROD_W-1:0] then_prod;
  logic                     vol;
  logic [SUM_W-1:0]         tempo_limit;
  logic [SUM_W-1:0]         scaled;
  logic [SUM_W-1:0]         dev;
  logic                     stab;
  logic [1:0]               score;
  logic                     hook;
  result_t                  result;

  // ---------------------------------------------------------------------
  // handshakes: a shifted frame moves to the output register whenever that
  // register is empty or being drained this cycle
  // ---------------------------------------------------------------------
  assign advance   = pending && (!out_valid || !out_stall);
  assign in_stall  = pending && !advance;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------------
  // configuration, out-of-range indexes ignored
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_off        <= COOLDOWN_RST;
      rise_threshold  <= RISE_THR_RST;
      tempo_tolerance <= TEMPO_TOL_RST;
      volume_gain     <= VOL_GAIN_RST;
      min_score       <= MIN_SCORE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_COOLDOWN:  hold_off        <= cfg_data;
        REG_RISE_THR:  rise_threshold  <= cfg_data;
        REG_TEMPO_TOL: tempo_tolerance <= cfg_data;
        REG_VOL_GAIN:  volume_gain     <= cfg_data;
        REG_MIN_SCORE: min_score       <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // history shift on acceptance; the tempo sum is kept running so the
  // flag stage needs no adder tree
  // ---------------------------------------------------------------------
  assign tempo_sum_next = SUM_W'(({1'b0, tempo_sum} + (SUM_W+1)'(in_data.tempo))
                                 - (SUM_W+1)'(tempo_window[TEMPO_WINDOW-1]));

  always_comb begin
    level_in.surround = in_data.surround_level;
    level_in.band_sum = 18'(in_data.band_hi) + 18'(in_data.band_mid)
                      + 18'(in_data.band_lo);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TEMPO_WINDOW; i++) begin
        tempo_window[i] <= '0;
      end
      for (int i = 0; i <= LAG; i++) begin
        level_delay[i] <= '0;
      end
      tempo_sum  <= '0;
      fill_count <= '0;
    end else if (accept) begin
      for (int i = TEMPO_WINDOW - 1; i > 0; i--) begin
        tempo_window[i] <= tempo_window[i-1];
      end
      tempo_window[0] <= in_data.tempo;
      for (int i = LAG; i > 0; i--) begin
        level_delay[i] <= level_delay[i-1];
      end
      level_delay[0] <= level_in;
      tempo_sum      <= tempo_sum_next;
      if (fill_count < FILL_W'(HISTORY_LEN)) begin
        fill_count <= fill_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else if (accept) begin
      pending <= 1'b1;
    end else if (advance) begin
      pending <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------
  // flags, all forced low until the history is full
  // ---------------------------------------------------------------------
  assign full = (fill_count == FILL_W'(HISTORY_LEN));

  // surround rise over the lag
  assign surround_diff = 18'(level_delay[0].surround) - 18'(level_delay[LAG].surround);
  assign exc = full && (surround_diff >= $signed({2'b00, rise_threshold}));

  // volume: now * unity against then * gain, exact
  assign now_prod  = PROD_W'(level_delay[0].band_sum) <<< VOL_UNITY_SHIFT;
  assign then_prod = PROD_W'(level_delay[LAG].band_sum)
                   * PROD_W'($signed({1'b0, volume_gain}));
  assign vol = full && (now_prod > then_prod);

  // tempo: every |N*t - sum| below N*tol
  assign tempo_limit = SUM_W'(tempo_tolerance) * SUM_W'(TEMPO_WINDOW);

  always_comb begin
    stab   = full;
    scaled = '0;
    dev    = '0;
    for (int i = 0; i < TEMPO_WINDOW; i++) begin
      scaled = SUM_W'(tempo_window[i]) * SUM_W'(TEMPO_WINDOW);
      dev    = (scaled >= tempo_sum) ? scaled - tempo_sum : tempo_sum - scaled;
      if (dev >= tempo_limit) begin
        stab = 1'b0;
      end
    end
  end

  assign score = 2'(exc) + 2'(vol) + 2'(stab);
  assign hook  = (score >= min_score) && (gap > hold_off);

  always_comb begin
    result.excitement_rise = exc;
    result.volume_rise     = vol;
    result.tempo_stable    = stab;
    result.flag_total      = score;
    result.hook_detected   = hook;
  end

  // ---------------------------------------------------------------------
  // gap counter, stepped once per scored frame, saturating
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      gap <= GAP_RST;
    end else if (advance) begin
      if (hook) begin
        gap <= 16'd1;
      end else if (gap != GAP_MAX) begin
        gap <= gap + 16'd1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  a_pending_kept: assert property (@(posedge clk) disable iff (rst)
    pending && !advance |=> pending)
    else $error("shifted frame dropped before scoring");

  a_hook_resets_gap: assert property (@(posedge clk) disable iff (rst)
    advance && hook |=> gap == 16'd1)
    else $error("gap not restarted after hook");

  a_partial_history: assert property (@(posedge clk) disable iff (rst)
    advance && !full |=> out_data.flag_total == 2'd0)
    else $error("score set before history full");

  a_score_count: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.flag_total == 2'($countones({out_data.excitement_rise,
      out_data.volume_rise, out_data.tempo_stable})))
    else $error("score does not match flags");

endmodule

`default_nettype wire

[bench/tb_audio_hook_detector.sv]
`timescale 1ns / 1ps

module tb_audio_hook_detector;
  import adh_pkg::*;

  localparam int PHASES       = 8;
  localparam int PHASE_FRAMES = 150;
  localparam int OPENING      = 25;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int REG_SLOTS    = 8;                        // cfg_index is three bits wide
  localparam int REG_COUNT    = int'(REG_MIN_SCORE) + 1;  // slots from this index up are unused

  typedef struct {
    logic [15:0] cooldown, rise_thr, tempo_tol, vol_gain;
    logic [1:0]  min_score;
  } reg_set_t;

  // mirror of the detector: history, gap counter, registers and the queue
  // of hook results still owed by the block
  class hook_tracker;
    logic [15:0]        tempo_hist [TEMPO_WINDOW_DEF];
    logic signed [15:0] surr_hist  [LAG_DEF + 1];
    longint             band_hist  [LAG_DEF + 1];
    int                 filled;
    logic [15:0]        gap;
    logic [15:0]        cooldown, rise_thr, tempo_tol, vol_gain;
    logic [1:0]         min_score;
    result_t            awaited [$];
    int failures, frames, exc_seen, vol_seen, stab_seen, hooks_seen;

    function new();
      int i;
      for (i = 0; i < TEMPO_WINDOW_DEF; i++) tempo_hist[i] = '0;
      for (i = 0; i <= LAG_DEF; i++) begin
        surr_hist[i] = '0;
        band_hist[i] = 0;
      end
      filled     = 0;
      gap        = GAP_RST;
      cooldown   = COOLDOWN_RST;
      rise_thr   = RISE_THR_RST;
      tempo_tol  = TEMPO_TOL_RST;
      vol_gain   = VOL_GAIN_RST;
      min_score  = MIN_SCORE_RST;
      failures   = 0;
      frames     = 0;
      exc_seen   = 0;
      vol_seen   = 0;
      stab_seen  = 0;
      hooks_seen = 0;
    endfunction

    function void set_register(logic [2:0] idx, logic [15:0] val);
      case (idx)
        REG_COOLDOWN:  cooldown  = val;
        REG_RISE_THR:  rise_thr  = val;
        REG_TEMPO_TOL: tempo_tol = val;
        REG_VOL_GAIN:  vol_gain  = val;
        REG_MIN_SCORE: min_score = val[1:0];
        default: ;  // unused slot, write dropped
      endcase
    endfunction

    // shift one accepted frame in and queue the result it must produce
    function void take_frame(frame_t f);
      result_t r;
      int      i, score;
      longint  tsum, dev, lim;
      frames++;
      for (i = TEMPO_WINDOW_DEF - 1; i > 0; i--) tempo_hist[i] = tempo_hist[i - 1];
      tempo_hist[0] = f.tempo;
      for (i = LAG_DEF; i > 0; i--) begin
        surr_hist[i] = surr_hist[i - 1];
        band_hist[i] = band_hist[i - 1];
      end
      surr_hist[0] = f.surround_level;
      band_hist[0] = longint'(f.band_hi) + longint'(f.band_mid)
                   + longint'(f.band_lo);
      if (filled < HISTORY_LEN_DEF) filled++;

      r = '0;
      if (filled >= HISTORY_LEN_DEF) begin
        r.excitement_rise = (longint'(surr_hist[0]) - longint'(surr_hist[LAG_DEF])
                             >= longint'(rise_thr));
        // exact cross-multiplied ratio test against the Q2.14 gain
        r.volume_rise = (band_hist[0] * (longint'(1) << VOL_UNITY_SHIFT)
                         > band_hist[LAG_DEF] * longint'(vol_gain));
        tsum = 0;
        for (i = 0; i < TEMPO_WINDOW_DEF; i++) tsum += longint'(tempo_hist[i]);
        lim = longint'(TEMPO_WINDOW_DEF) * longint'(tempo_tol);
        r.tempo_stable = 1'b1;
        for (i = 0; i < TEMPO_WINDOW_DEF; i++) begin
          dev = longint'(TEMPO_WINDOW_DEF) * longint'(tempo_hist[i]) - tsum;
          if (dev < 0) dev = -dev;
          if (dev >= lim) r.tempo_stable = 1'b0;
        end
      end
      score = r.excitement_rise + r.volume_rise + r.tempo_stable;
      r.flag_total    = score[1:0];
      r.hook_detected = (r.flag_total >= min_score) && (gap > cooldown);
      if (r.hook_detected) gap = 16'd1;
      else if (gap != GAP_MAX) gap = gap + 16'd1;
      awaited.push_back(r);
    endfunction

    function void compare_field(string name, logic [1:0] want, logic [1:0] got);
      if (got !== want) begin
        failures++;
        $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      end
    endfunction

    function void match_result(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        failures++;
        $display("%0t: result word %b with no frame behind it", $time, got);
        return;
      end
      want = awaited.pop_front();
      exc_seen   += want.excitement_rise;
      vol_seen   += want.volume_rise;
      stab_seen  += want.tempo_stable;
      hooks_seen += want.hook_detected;
      compare_field("excitement_rise", want.excitement_rise, got.excitement_rise);
      compare_field("volume_rise", want.volume_rise, got.volume_rise);
      compare_field("tempo_stable", want.tempo_stable, got.tempo_stable);
      compare_field("flag_total", want.flag_total, got.flag_total);
      compare_field("hook_detected", want.hook_detected, got.hook_detected);
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  frame_t      in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  result_t     out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data  = '0;

  hook_tracker book = new();
  reg_set_t    cur;
  int          idle_pct  = 0;
  int          stall_pct = 0;
  int          cycles    = 0;

  // state of the synthetic song used for most random frames
  int seg_left = 0;
  int base_tempo, jitter, surr, surr_step, vol, vol_step;

  audio_hook_detector u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result side: take a word whenever one is offered and not stalled
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) book.match_result(out_data);
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: watchdog expired with %0d results owed", $time, book.awaited.size());
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [15:0] clamp_level(int v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  // leaves cfg_valid high, the caller lowers it after the last write
  task automatic write_register(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    book.set_register(idx, val);
  endtask

  task automatic write_settings(input reg_set_t s);
    write_register(REG_COOLDOWN, s.cooldown);
    write_register(REG_RISE_THR, s.rise_thr);
    write_register(REG_TEMPO_TOL, s.tempo_tol);
    write_register(REG_VOL_GAIN, s.vol_gain);
    write_register(REG_MIN_SCORE, {14'd0, s.min_score});
    cfg_valid <= 1'b0;
    cur = s;
  endtask

  // in_valid stays high after acceptance so back-to-back words need no second
  // assignment in one step; it is lowered only on idle cycles and while draining
  task automatic send_frame(input frame_t f);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= f;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    book.take_frame(f);
  endtask

  // sender pauses until every owed result has come back
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (book.awaited.size() != 0);
  endtask

  // mostly song-like segments: tempo jitter scaled to the tolerance,
  // surround ramps near the rise threshold, band levels drifting; the rest
  // is full-range noise that breaks the segments up
  task automatic next_frame(output frame_t f);
    int spread, thr;
    if (seg_left == 0) begin
      seg_left = $urandom_range(12, 40);
      case ($urandom_range(0, 3))
        0:       spread = 0;
        1:       spread = int'(cur.tempo_tol) / 4;
        2:       spread = int'(cur.tempo_tol);
        default: spread = 3 * int'(cur.tempo_tol) + 1;
      endcase
      jitter     = (spread > 65535) ? 65535 : spread;
      base_tempo = $urandom_range(0, 65535 - jitter);
      thr        = int'(cur.rise_thr);
      surr       = int'($urandom_range(0, 65535)) - 32768;
      surr_step  = int'($urandom_range(0, thr / 5 + 8)) - thr / 20 - 4;
      vol        = int'($urandom_range(0, 24000)) - 8000;
      vol_step   = int'($urandom_range(0, 800)) - 300;
    end
    seg_left--;
    if ($urandom_range(0, 99) < 15) begin
      f.tempo          = 16'($urandom);
      f.surround_level = 16'($urandom);
      f.band_hi        = 16'($urandom);
      f.band_mid       = 16'($urandom);
      f.band_lo        = 16'($urandom);
    end else begin
      surr = $signed(clamp_level(surr + surr_step));
      vol  = $signed(clamp_level(vol + vol_step));
      f.tempo          = 16'(base_tempo + int'($urandom_range(0, jitter)));
      f.surround_level = 16'(surr);
      f.band_hi        = clamp_level(vol + int'($urandom_range(0, 127)) - 64);
      f.band_mid       = clamp_level(vol + int'($urandom_range(0, 127)) - 64);
      f.band_lo        = clamp_level(vol + int'($urandom_range(0, 127)) - 64);
    end
  endtask

  initial begin
    int               n, ph, k;
    frame_t           f;
    logic signed [15:0] lvl;
    reg_set_t         s;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // opening: any score passes and a short cooldown, so hooks fire while
    // the history is still filling; writes to unused slots must be dropped
    cur = '{COOLDOWN_RST, RISE_THR_RST, TEMPO_TOL_RST, VOL_GAIN_RST, MIN_SCORE_RST};
    write_register(REG_MIN_SCORE, 16'd0);
    write_register(REG_COOLDOWN, 16'd3);
    for (k = REG_COUNT; k < REG_SLOTS; k++) write_register(3'(k), 16'hffff);
    cfg_valid <= 1'b0;
    cur.min_score = 2'd0;
    cur.cooldown  = 16'd3;

    // first ten frames at the field extremes, then a steady tempo with the
    // surround pinned high, so all three flags rise once the history fills
    for (n = 0; n < OPENING; n++) begin
      if (n < LAG_DEF) begin
        case (n % 3)
          0: begin f.tempo = 16'h0000; lvl = 16'sh8000; end
          1: begin f.tempo = 16'hffff; lvl = 16'sh7fff; end
          default: begin f.tempo = 16'h0001; lvl = -16'sd1; end
        endcase
        f.surround_level = lvl;
      end else begin
        f.tempo          = 16'd15360 + 16'(n % 2) * 16'd64;
        f.surround_level = 16'sh7fff;
        lvl              = (n < HISTORY_LEN_DEF) ? 16'sh2000 : 16'sh3000;
      end
      f.band_hi  = lvl;
      f.band_mid = lvl;
      f.band_lo  = lvl;
      send_frame(f);
    end
    hold_until_drained();

    // random phases; idling pattern cycles none / sender / receiver / both
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: s = '{COOLDOWN_RST, RISE_THR_RST, TEMPO_TOL_RST, VOL_GAIN_RST, MIN_SCORE_RST};
        1: s = '{16'd0, 16'd0, 16'd0, 16'd0, 2'd0};
        2: s = '{16'hffff, 16'hffff, 16'hffff, 16'hffff, 2'd3};
        default: begin
          s.cooldown  = 16'($urandom_range(0, 40));
          s.rise_thr  = 16'($urandom_range(0, 4000));
          s.tempo_tol = 16'($urandom_range(0, 2000));
          s.vol_gain  = 16'($urandom_range(8192, 32767));
          s.min_score = 2'($urandom_range(0, 3));
        end
      endcase
      write_settings(s);
      case (ph % 4)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 85; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 85; end
        default: begin idle_pct = 13; stall_pct = 13; end
      endcase
      for (n = 0; n < PHASE_FRAMES; n++) begin
        if (n == PHASE_FRAMES / 2) hold_until_drained();
        next_frame(f);
        send_frame(f);
      end
      hold_until_drained();
    end

    // let the two-stage pipe settle in case of a stray word
    stall_pct = 0;
    repeat (8) @(posedge clk);

    $display("run covered %0d frames over %0d register settings and four idling patterns",
             book.frames, PHASES + 1);
    $display("flags seen: surround rise %0d, volume rise %0d, steady tempo %0d, hooks %0d",
             book.exc_seen, book.vol_seen, book.stab_seen, book.hooks_seen);
    if (book.awaited.size() != 0)
      $display("%0t: %0d results never arrived", $time, book.awaited.size());
    if (book.failures == 0 && book.awaited.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
